// ----- rtl/hmbs_pkg.sv -----
`default_nettype none

package hmbs_pkg;

   localparam int DATA_W     = 32;
   localparam int FRAC_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int SIZE_REG_W = 8;
   localparam int LOAD_IDX_W = 7;
   // wide enough for any grid dimension up to 1024
   localparam int DIM_W      = 11;

   localparam int DEF_MAX_COLUMNS = 128;
   localparam int DEF_MAX_ROWS    = 128;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Z     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_CELL_X   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_CELL_Z   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR_Y      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CEILING_Y    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLUMNS = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS    = 3'd7;

   localparam logic [DATA_W-1:0]     ORIGIN_RESET   = 32'h0000_0000;
   localparam logic [DATA_W-1:0]     INV_CELL_RESET = 32'h0001_0000;
   localparam logic [DATA_W-1:0]     FLOOR_RESET    = 32'h8000_0000;
   localparam logic [DATA_W-1:0]     CEILING_RESET  = 32'h7fff_ffff;
   localparam logic [SIZE_REG_W-1:0] SIZE_RESET     = 8'd128;

   // per-axis mapping setup handed to the coordinate pipeline
   typedef struct packed {
      logic [DATA_W-1:0] origin;
      logic [DATA_W-1:0] inv_cell;
   } axis_cfg_type;

endpackage

`default_nettype wire

// ----- rtl/hmbs_ram.sv -----
`default_nettype none

module hmbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/hmbs_axis.sv -----
`default_nettype none

// Coordinate to grid index pipeline: subtract, scale, clamp, split.
// coord passes the dist, prod and pos registers, in that order, before idx0/idx1/frac.
module hmbs_axis import hmbs_pkg::*; #(
   parameter int IDX_W = 7,
   localparam int SIZE_W = IDX_W + 1
) (
   input  wire logic                clock,
   input  wire logic [DATA_W-1:0]   coord,
   input  wire axis_cfg_type        cfg,
   input  wire logic [SIZE_W-1:0]   size,
   output logic      [IDX_W-1:0]    idx0,
   output logic      [IDX_W-1:0]    idx1,
   output logic      [FRAC_W-1:0]   frac
);

   localparam int POS_W  = SIZE_W + FRAC_W;
   localparam int PROD_W = 2 * DATA_W;

   logic signed [DATA_W:0]    diff;
   logic [DATA_W-1:0]         dist_in, dist_ff;
   logic [PROD_W-1:0]         prod_in, prod_ff;
   logic [PROD_W-FRAC_W-1:0]  scaled;
   logic [POS_W-1:0]          lim;
   logic [POS_W-1:0]          pos_in, pos_ff;
   logic [SIZE_W-1:0]         ix, last;
   logic [SIZE_W:0]           ix_next;

   assign diff = $signed({coord[DATA_W-1], coord})
               - $signed({cfg.origin[DATA_W-1], cfg.origin});
   // at or left of the origin maps to position zero
   assign dist_in = diff[DATA_W] ? '0 : diff[DATA_W-1:0];

   assign prod_in = PROD_W'(dist_ff) * PROD_W'(cfg.inv_cell);

   assign scaled = prod_ff[PROD_W-1:FRAC_W];
   assign lim    = {size, {FRAC_W{1'b0}}};
   assign pos_in = (scaled > (PROD_W-FRAC_W)'(lim)) ? lim : scaled[POS_W-1:0];

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
      prod_ff <= prod_in;
      pos_ff  <= pos_in;
   end

   assign ix      = pos_ff[POS_W-1:FRAC_W];
   assign last    = size - 1'b1;
   assign ix_next = (SIZE_W+1)'(ix) + 1'b1;
   assign idx0    = IDX_W'((ix > last) ? last : ix);
   assign idx1    = IDX_W'((ix_next > {1'b0, last}) ? {1'b0, last} : ix_next);
   assign frac    = pos_ff[FRAC_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/hmbs_lerp.sv -----
`default_nettype none

// y = a + floor((b - a) * frac / 2^16), three register stages
module hmbs_lerp import hmbs_pkg::*; (
   input  wire logic                     clock,
   input  wire logic signed [DATA_W-1:0] a,
   input  wire logic signed [DATA_W-1:0] b,
   input  wire logic        [FRAC_W-1:0] frac,
   output logic      signed [DATA_W-1:0] y
);

   localparam int PROD_W = DATA_W + FRAC_W + 2;

   logic signed [DATA_W:0]   diff_in, diff_ff;
   logic signed [DATA_W-1:0] base_ff, base2_ff;
   logic        [FRAC_W-1:0] frac_ff;
   logic signed [PROD_W-1:0] prod_in, prod_ff;
   logic signed [DATA_W-1:0] y_in, y_ff;

   assign diff_in = $signed({b[DATA_W-1], b}) - $signed({a[DATA_W-1], a});
   assign prod_in = diff_ff * $signed({1'b0, frac_ff});
   // arithmetic shift floors; the mix never leaves the range of a and b
   assign y_in    = DATA_W'(base2_ff + (prod_ff >>> FRAC_W));

   always_ff @(posedge clock) begin
      diff_ff  <= diff_in;
      base_ff  <= a;
      frac_ff  <= frac;
      prod_ff  <= prod_in;
      base2_ff <= base_ff;
      y_ff     <= y_in;
   end

   assign y = y_ff;

endmodule

`default_nettype wire

// ----- rtl/heightmap_bilinear_sampler_unit.sv -----
`default_nettype none

// A query runs the axis mapping, bank read, lerp levels and height register before rsp_*.
// Throughput: one word (load or query) per cycle while busy is low; the grid sits in four
// banks split by column and row parity, so all four neighbours are read in the same cycle.
// Loads pass the ld_* registers to the bank write, in order with earlier queries' reads.
// Reset clears the registers to their defaults and empties the pipeline; grid contents
// are undefined until loaded. The receiver cannot stall: rsp_strobe lasts one cycle.
module heightmap_bilinear_sampler_unit import hmbs_pkg::*; #(
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic                        req_action,
   input  wire logic        [LOAD_IDX_W-1:0] req_column,
   input  wire logic        [LOAD_IDX_W-1:0] req_row,
   input  wire logic signed [DATA_W-1:0]    req_sample,
   input  wire logic signed [DATA_W-1:0]    req_query_x,
   input  wire logic signed [DATA_W-1:0]    req_query_z,
   output logic                             rsp_strobe,
   output logic      signed [DATA_W-1:0]    rsp_height,
   input  wire logic                        csr_we,
   input  wire logic        [CSR_IDX_W-1:0] csr_index,
   input  wire logic        [DATA_W-1:0]    csr_wdata
);

   localparam int XW  = $clog2(MAX_COLUMNS);
   localparam int ZW  = $clog2(MAX_ROWS);
   localparam int CAW = ($clog2((MAX_COLUMNS + 1) / 2) > 0) ? $clog2((MAX_COLUMNS + 1) / 2) : 1;
   localparam int RAW = ($clog2((MAX_ROWS + 1) / 2) > 0) ? $clog2((MAX_ROWS + 1) / 2) : 1;
   localparam int BANK_AW    = CAW + RAW;
   localparam int BANK_DEPTH = 2 ** BANK_AW;
   localparam int QRY_STAGES = 10;
   localparam int LD_STAGES  = 3;

   // configuration
   logic        [DATA_W-1:0]     origin_x_ff, origin_z_ff, inv_cell_x_ff, inv_cell_z_ff;
   logic signed [DATA_W-1:0]     floor_y_ff, ceiling_y_ff;
   logic        [SIZE_REG_W-1:0] grid_columns_ff, grid_rows_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff     <= ORIGIN_RESET;
         origin_z_ff     <= ORIGIN_RESET;
         inv_cell_x_ff   <= INV_CELL_RESET;
         inv_cell_z_ff   <= INV_CELL_RESET;
         floor_y_ff      <= FLOOR_RESET;
         ceiling_y_ff    <= CEILING_RESET;
         grid_columns_ff <= SIZE_RESET;
         grid_rows_ff    <= SIZE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ORIGIN_X:     origin_x_ff     <= csr_wdata;
            CSR_ORIGIN_Z:     origin_z_ff     <= csr_wdata;
            CSR_INV_CELL_X:   inv_cell_x_ff   <= csr_wdata;
            CSR_INV_CELL_Z:   inv_cell_z_ff   <= csr_wdata;
            CSR_FLOOR_Y:      floor_y_ff      <= csr_wdata;
            CSR_CEILING_Y:    ceiling_y_ff    <= csr_wdata;
            CSR_GRID_COLUMNS: grid_columns_ff <= csr_wdata[SIZE_REG_W-1:0];
            CSR_GRID_ROWS:    grid_rows_ff    <= csr_wdata[SIZE_REG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // grid size in use: zero acts as one, capped at storage size
   logic [DIM_W-1:0] cols_wide, rows_wide, cols_sel, rows_sel;
   logic [XW:0]      cols_eff;
   logic [ZW:0]      rows_eff;

   assign cols_wide = DIM_W'(grid_columns_ff);
   assign rows_wide = DIM_W'(grid_rows_ff);
   assign cols_sel  = (cols_wide == '0) ? DIM_W'(1) :
                      (cols_wide > DIM_W'(MAX_COLUMNS)) ? DIM_W'(MAX_COLUMNS) : cols_wide;
   assign rows_sel  = (rows_wide == '0) ? DIM_W'(1) :
                      (rows_wide > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : rows_wide;
   assign cols_eff  = cols_sel[XW:0];
   assign rows_eff  = rows_sel[ZW:0];

   // accept
   logic accept;
   logic busy_ff;

   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   // control pipeline
   logic [QRY_STAGES-1:0] qry_vld_ff;
   logic [LD_STAGES-1:0]  ld_vld_ff;
   logic                  rsp_strobe_ff;
   logic                  ld_ok;
   logic [DIM_W-1:0]      ld_col_wide, ld_row_wide;

   assign ld_col_wide = DIM_W'(req_column);
   assign ld_row_wide = DIM_W'(req_row);
   assign ld_ok = (ld_col_wide < DIM_W'(MAX_COLUMNS)) && (ld_row_wide < DIM_W'(MAX_ROWS));

   always_ff @(posedge clock) begin
      if (reset) begin
         qry_vld_ff    <= '0;
         ld_vld_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         qry_vld_ff    <= {qry_vld_ff[QRY_STAGES-2:0], accept && req_action};
         ld_vld_ff     <= {ld_vld_ff[LD_STAGES-2:0], accept && !req_action && ld_ok};
         rsp_strobe_ff <= qry_vld_ff[QRY_STAGES-1];
      end
   end

   // load word travels alongside the address pipeline
   logic [XW-1:0]     ld_col_ff  [LD_STAGES];
   logic [ZW-1:0]     ld_row_ff  [LD_STAGES];
   logic [DATA_W-1:0] ld_data_ff [LD_STAGES];

   always_ff @(posedge clock) begin
      ld_col_ff[0]  <= ld_col_wide[XW-1:0];
      ld_row_ff[0]  <= ld_row_wide[ZW-1:0];
      ld_data_ff[0] <= req_sample;
      for (int s = 1; s < LD_STAGES; s++) begin
         ld_col_ff[s]  <= ld_col_ff[s-1];
         ld_row_ff[s]  <= ld_row_ff[s-1];
         ld_data_ff[s] <= ld_data_ff[s-1];
      end
   end

   // coordinate mapping
   axis_cfg_type      cfg_x, cfg_z;
   logic [XW-1:0]     x0, x1;
   logic [ZW-1:0]     z0, z1;
   logic [FRAC_W-1:0] fx, fz;

   assign cfg_x = '{origin: origin_x_ff, inv_cell: inv_cell_x_ff};
   assign cfg_z = '{origin: origin_z_ff, inv_cell: inv_cell_z_ff};

   hmbs_axis #(.IDX_W(XW)) u_axis_x (
      .clock (clock),
      .coord (req_query_x),
      .cfg   (cfg_x),
      .size  (cols_eff),
      .idx0  (x0),
      .idx1  (x1),
      .frac  (fx)
   );

   hmbs_axis #(.IDX_W(ZW)) u_axis_z (
      .clock (clock),
      .coord (req_query_z),
      .cfg   (cfg_z),
      .size  (rows_eff),
      .idx0  (z0),
      .idx1  (z1),
      .frac  (fz)
   );

   // bank address: halves of column and row, bank picked by their parities
   function automatic logic [BANK_AW-1:0] bank_addr(input logic [XW-1:0] c,
                                                    input logic [ZW-1:0] r);
      logic [XW-1:0] ch;
      logic [ZW-1:0] rh;
      ch = c >> 1;
      rh = r >> 1;
      return {rh[RAW-1:0], ch[CAW-1:0]};
   endfunction

   logic [DATA_W-1:0] bank_q [4];

   for (genvar b = 0; b < 4; b++) begin : g_bank
      localparam bit PX = (b % 2) == 1;
      localparam bit PZ = (b / 2) == 1;
      logic [XW-1:0] rd_col;
      logic [ZW-1:0] rd_row;
      logic          we;

      assign rd_col = (x0[0] == PX) ? x0 : x1;
      assign rd_row = (z0[0] == PZ) ? z0 : z1;
      assign we     = ld_vld_ff[LD_STAGES-1]
                   && (ld_col_ff[LD_STAGES-1][0] == PX)
                   && (ld_row_ff[LD_STAGES-1][0] == PZ);

      hmbs_ram #(.WIDTH(DATA_W), .DEPTH(BANK_DEPTH)) u_ram (
         .clock   (clock),
         .wr_en   (we),
         .wr_addr (bank_addr(ld_col_ff[LD_STAGES-1], ld_row_ff[LD_STAGES-1])),
         .wr_data (ld_data_ff[LD_STAGES-1]),
         .rd_addr (bank_addr(rd_col, rd_row)),
         .rd_data (bank_q[b])
      );
   end

   // neighbour parities and fractions, aligned with bank read data
   logic              x0p_ff, x1p_ff, z0p_ff, z1p_ff;
   logic [FRAC_W-1:0] fx_ff, fz_ff;
   logic [FRAC_W-1:0] fz_dly_ff [3];

   always_ff @(posedge clock) begin
      x0p_ff       <= x0[0];
      x1p_ff       <= x1[0];
      z0p_ff       <= z0[0];
      z1p_ff       <= z1[0];
      fx_ff        <= fx;
      fz_ff        <= fz;
      fz_dly_ff[0] <= fz_ff;
      fz_dly_ff[1] <= fz_dly_ff[0];
      fz_dly_ff[2] <= fz_dly_ff[1];
   end

   logic signed [DATA_W-1:0] a00, a10, a01, a11;

   assign a00 = bank_q[{z0p_ff, x0p_ff}];
   assign a10 = bank_q[{z0p_ff, x1p_ff}];
   assign a01 = bank_q[{z1p_ff, x0p_ff}];
   assign a11 = bank_q[{z1p_ff, x1p_ff}];

   // interpolation: along x on both rows, then along z
   logic signed [DATA_W-1:0] y_near, y_far, y_mix;

   hmbs_lerp u_lerp_near (
      .clock (clock),
      .a     (a00),
      .b     (a10),
      .frac  (fx_ff),
      .y     (y_near)
   );

   hmbs_lerp u_lerp_far (
      .clock (clock),
      .a     (a01),
      .b     (a11),
      .frac  (fx_ff),
      .y     (y_far)
   );

   hmbs_lerp u_lerp_z (
      .clock (clock),
      .a     (y_near),
      .b     (y_far),
      .frac  (fz_dly_ff[2]),
      .y     (y_mix)
   );

   // floor first, ceiling last so the ceiling wins
   logic signed [DATA_W-1:0] y_lo, height_in, height_ff;

   assign y_lo      = (y_mix < floor_y_ff) ? floor_y_ff : y_mix;
   assign height_in = (y_lo > ceiling_y_ff) ? ceiling_y_ff : y_lo;

   always_ff @(posedge clock) begin
      height_ff <= height_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_height = height_ff;

   // neighbour indices differ by at most one along each axis
   assert property (@(posedge clock) disable iff (reset)
      qry_vld_ff[2] |-> ((x1 == x0) || (x1 == x0 + 1'b1)) && ((z1 == z0) || (z1 == z0 + 1'b1)))
      else $error("neighbour indices not adjacent");

   // a result word comes from a query that was accepted and ran the full query pipeline
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(accept && req_action, 11))
      else $error("result word without matching query");

   // grid writes only for an accepted load that has run the load pipeline
   assert property (@(posedge clock) disable iff (reset)
      ld_vld_ff[LD_STAGES-1] |-> $past(accept && !req_action, 3))
      else $error("grid write without matching load");

   // returned height stays within the configured band
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && (floor_y_ff <= ceiling_y_ff))
      |-> ((height_ff >= floor_y_ff) && (height_ff <= ceiling_y_ff)))
      else $error("height outside floor/ceiling band");

endmodule

`default_nettype wire

// ----- tb/heightmap_bilinear_sampler_unit_tb.sv -----
module heightmap_bilinear_sampler_unit_tb;
   import hmbs_pkg::*;

   localparam int GRID_STRIDE = DEF_MAX_COLUMNS;
   localparam int GRID_WORDS  = DEF_MAX_COLUMNS * DEF_MAX_ROWS;
   localparam int PHASE_DRAWS = 100;
   localparam int SETTLE      = 16;
   localparam int CYCLE_LIMIT = 400000;

   typedef enum logic {ACT_LOAD = 1'b0, ACT_QUERY = 1'b1} action_type;

   typedef struct {
      action_type               action;
      logic [LOAD_IDX_W-1:0]    column;
      logic [LOAD_IDX_W-1:0]    row;
      logic signed [DATA_W-1:0] sample;
      logic signed [DATA_W-1:0] query_x;
      logic signed [DATA_W-1:0] query_z;
   } grid_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_action = 1'b0;
   logic [LOAD_IDX_W-1:0] req_column = '0;
   logic [LOAD_IDX_W-1:0] req_row = '0;
   logic signed [DATA_W-1:0] req_sample = '0;
   logic signed [DATA_W-1:0] req_query_x = '0;
   logic signed [DATA_W-1:0] req_query_z = '0;
   logic rsp_strobe;
   logic signed [DATA_W-1:0] rsp_height;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DATA_W-1:0] csr_wdata = '0;

   heightmap_bilinear_sampler_unit uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_column(req_column), .req_row(req_row),
      .req_sample(req_sample), .req_query_x(req_query_x), .req_query_z(req_query_z),
      .rsp_strobe(rsp_strobe), .rsp_height(rsp_height),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   grid_word_type            words_to_send[$];
   grid_word_type            on_bus;
   logic signed [DATA_W-1:0] heights_due[$];
   logic signed [DATA_W-1:0] heights[0:GRID_WORDS-1];
   bit                       loaded_cells[0:GRID_WORDS-1];
   logic [DATA_W-1:0]        csr_shadow[0:7];
   int                       gap_pct = 0;
   int                       mismatches = 0;
   int                       cycles = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   // grid position along one axis -> clamped neighbour indices and 16-bit fraction
   function automatic void locate(input logic [DATA_W-1:0] q, input logic [DATA_W-1:0] org,
                                  input logic [DATA_W-1:0] inv,
                                  input logic [SIZE_REG_W-1:0] size_reg, input int max_dim,
                                  output int lo, output int hi, output int frac);
      int                dim;
      int                ix;
      longint            d;
      longint unsigned   du;
      longint unsigned   p;
      dim = (size_reg == 0) ? 1 : ((int'(size_reg) > max_dim) ? max_dim : int'(size_reg));
      d = longint'(signed'(q)) - longint'(signed'(org));
      if (d <= 0) begin
         p = 0;
      end else begin
         du = d;
         p = (du * inv) >> FRAC_W;
      end
      if (p > (longint'(dim) << FRAC_W)) p = longint'(dim) << FRAC_W;
      ix = int'(p >> FRAC_W);
      frac = int'(p & 64'hFFFF);
      lo = (ix > dim - 1) ? dim - 1 : ix;
      hi = (ix + 1 > dim - 1) ? dim - 1 : ix + 1;
   endfunction

   // floor((a*(1-f) + b*f)), f in 1/65536 steps
   function automatic logic signed [DATA_W-1:0] blend(logic signed [DATA_W-1:0] a,
                                                      logic signed [DATA_W-1:0] b, int f);
      longint s;
      s = longint'(a) * (65536 - f) + longint'(b) * f;
      s = s >>> FRAC_W;
      return s[DATA_W-1:0];
   endfunction

   function automatic logic signed [DATA_W-1:0] interp_height(logic [DATA_W-1:0] qx,
                                                              logic [DATA_W-1:0] qz);
      int x0, x1, z0, z1, fx, fz;
      logic signed [DATA_W-1:0] top, bot, y, lo_y, hi_y;
      locate(qx, csr_shadow[CSR_ORIGIN_X], csr_shadow[CSR_INV_CELL_X],
             csr_shadow[CSR_GRID_COLUMNS][SIZE_REG_W-1:0], DEF_MAX_COLUMNS, x0, x1, fx);
      locate(qz, csr_shadow[CSR_ORIGIN_Z], csr_shadow[CSR_INV_CELL_Z],
             csr_shadow[CSR_GRID_ROWS][SIZE_REG_W-1:0], DEF_MAX_ROWS, z0, z1, fz);
      top = blend(heights[z0*GRID_STRIDE + x0], heights[z0*GRID_STRIDE + x1], fx);
      bot = blend(heights[z1*GRID_STRIDE + x0], heights[z1*GRID_STRIDE + x1], fx);
      y = blend(top, bot, fz);
      lo_y = csr_shadow[CSR_FLOOR_Y];
      hi_y = csr_shadow[CSR_CEILING_Y];
      if (y < lo_y) y = lo_y;
      if (y > hi_y) y = hi_y;   // ceiling wins over floor
      return y;
   endfunction

   task automatic absorb_word(grid_word_type w);
      if (w.action == ACT_LOAD) begin
         heights[w.row*GRID_STRIDE + w.column] = w.sample;
      end else begin
         heights_due.push_back(interp_height(w.query_x, w.query_z));
      end
   endtask

   function automatic logic [DATA_W-1:0] pick_sample();
      case ($urandom_range(3))
         0: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         1: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
         default: return $urandom;
      endcase
   endfunction

   task automatic push_load(int c, int r, logic [DATA_W-1:0] s);
      grid_word_type w;
      w = '{ACT_LOAD, c[LOAD_IDX_W-1:0], r[LOAD_IDX_W-1:0], s, $urandom, $urandom};
      loaded_cells[r*GRID_STRIDE + c] = 1'b1;
      words_to_send.push_back(w);
   endtask

   task automatic ensure_loaded(int c, int r);
      if (!loaded_cells[r*GRID_STRIDE + c]) push_load(c, r, pick_sample());
   endtask

   // never read a grid word that was not loaded: fill in missing neighbours first
   task automatic push_query(logic [DATA_W-1:0] qx, logic [DATA_W-1:0] qz);
      int x0, x1, z0, z1, f;
      grid_word_type w;
      locate(qx, csr_shadow[CSR_ORIGIN_X], csr_shadow[CSR_INV_CELL_X],
             csr_shadow[CSR_GRID_COLUMNS][SIZE_REG_W-1:0], DEF_MAX_COLUMNS, x0, x1, f);
      locate(qz, csr_shadow[CSR_ORIGIN_Z], csr_shadow[CSR_INV_CELL_Z],
             csr_shadow[CSR_GRID_ROWS][SIZE_REG_W-1:0], DEF_MAX_ROWS, z0, z1, f);
      ensure_loaded(x0, z0);
      ensure_loaded(x1, z0);
      ensure_loaded(x0, z1);
      ensure_loaded(x1, z1);
      w = '{ACT_QUERY, LOAD_IDX_W'($urandom), LOAD_IDX_W'($urandom), $urandom, qx, qz};
      words_to_send.push_back(w);
   endtask

   // coordinate landing a little before, on or past the grid along one axis
   function automatic logic [DATA_W-1:0] aim(logic [DATA_W-1:0] org, logic [DATA_W-1:0] inv,
                                             logic [SIZE_REG_W-1:0] size_reg);
      longint unsigned cellw, span, r;
      cellw = (inv == 0) ? 64'd65536 : (64'h1_0000_0000 / inv);
      span = cellw * (longint'(size_reg) + 2);
      if (span > 64'h1_0000_0000) span = 64'h1_0000_0000;
      r = {$urandom, $urandom} % span;
      if ($urandom_range(5) == 0) r = (r / cellw) * cellw;
      return org + DATA_W'(r - cellw);
   endfunction

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_GRID_COLUMNS || idx == CSR_GRID_ROWS)
         csr_shadow[idx] = {24'd0, data[SIZE_REG_W-1:0]};
      else
         csr_shadow[idx] = data;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic setup_phase(int ph);
      logic [DATA_W-1:0] v[0:7];
      int t;
      v[CSR_ORIGIN_X] = ORIGIN_RESET;
      v[CSR_ORIGIN_Z] = ORIGIN_RESET;
      v[CSR_INV_CELL_X] = INV_CELL_RESET;
      v[CSR_INV_CELL_Z] = INV_CELL_RESET;
      v[CSR_FLOOR_Y] = FLOOR_RESET;
      v[CSR_CEILING_Y] = CEILING_RESET;
      v[CSR_GRID_COLUMNS] = SIZE_RESET;
      v[CSR_GRID_ROWS] = SIZE_RESET;
      case (ph)
         1: begin
            v[CSR_GRID_COLUMNS] = 4;
            v[CSR_GRID_ROWS] = 3;
         end
         2: begin
            v[CSR_ORIGIN_X] = 32'hFFFC_8000;
            v[CSR_ORIGIN_Z] = 32'h000A_4000;
            v[CSR_INV_CELL_X] = 32'h0002_0000;
            v[CSR_INV_CELL_Z] = 32'h0000_8000;
            v[CSR_FLOOR_Y] = 32'hFF9C_0000;
            v[CSR_CEILING_Y] = 32'h0064_0000;
            v[CSR_GRID_COLUMNS] = 8;
            v[CSR_GRID_ROWS] = 16;
         end
         3: begin
            // floor above ceiling, zero columns, degenerate mappings
            v[CSR_ORIGIN_X] = 32'h8000_0000;
            v[CSR_ORIGIN_Z] = 32'h7FFF_FFFF;
            v[CSR_INV_CELL_X] = 32'hFFFF_FFFF;
            v[CSR_INV_CELL_Z] = 32'h0000_0000;
            v[CSR_FLOOR_Y] = 32'h0005_0000;
            v[CSR_CEILING_Y] = 32'hFFFB_0000;
            v[CSR_GRID_COLUMNS] = 32'hFFFF_FF00;
            v[CSR_GRID_ROWS] = 1;
         end
         4: begin
            v[CSR_ORIGIN_X] = 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            v[CSR_ORIGIN_Z] = 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            v[CSR_GRID_COLUMNS] = 129;
            v[CSR_GRID_ROWS] = 2;
         end
         5, 8: begin
            for (int i = 0; i < 8; i++) v[i] = $urandom;
            if (ph == 8) begin
               v[CSR_GRID_COLUMNS] = $urandom_range(1, 8);
               v[CSR_GRID_ROWS] = $urandom_range(1, 8);
            end
         end
         6: begin
            v[CSR_GRID_ROWS] = 255;
         end
         default: begin
            v[CSR_ORIGIN_X] = 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
            v[CSR_ORIGIN_Z] = 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
            v[CSR_INV_CELL_X] = $urandom_range(32'h4000, 32'h4_0000);
            v[CSR_INV_CELL_Z] = $urandom_range(32'h4000, 32'h4_0000);
            t = $urandom_range(1, 2000);
            v[CSR_FLOOR_Y] = -t * 65536;
            t = $urandom_range(1, 2000);
            v[CSR_CEILING_Y] = t * 65536;
            v[CSR_GRID_COLUMNS] = $urandom_range(1, 16);
            v[CSR_GRID_ROWS] = $urandom_range(1, 16);
         end
      endcase
      for (int i = 0; i < 8; i++) csr_write(CSR_IDX_W'(i), v[i]);
   endtask

   task automatic wait_idle();
      while (words_to_send.size() != 0 || start || heights_due.size() != 0)
         @(posedge clock);
      // loads give no word back; let them land before touching registers
      repeat (SETTLE) @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      logic go;
      if (reset) begin
         start <= 1'b0;
      end else begin
         go = start;
         if (start && !busy) begin
            absorb_word(on_bus);
            go = 1'b0;
         end
         if (!go && words_to_send.size() != 0 && $urandom_range(99) >= gap_pct) begin
            on_bus = words_to_send.pop_front();
            req_action <= on_bus.action;
            req_column <= on_bus.column;
            req_row <= on_bus.row;
            req_sample <= on_bus.sample;
            req_query_x <= on_bus.query_x;
            req_query_z <= on_bus.query_z;
            go = 1'b1;
         end
         start <= go;
      end
   end

   // monitor
   always @(posedge clock) begin
      logic signed [DATA_W-1:0] want;
      if (!reset && rsp_strobe) begin
         if (heights_due.size() == 0) begin
            $error("height: no word expected, got %0d", rsp_height);
            mismatches++;
         end else begin
            want = heights_due.pop_front();
            if (rsp_height !== want) begin
               $error("height: expected %0d, got %0d", want, rsp_height);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      int k;
      csr_shadow[CSR_ORIGIN_X] = ORIGIN_RESET;
      csr_shadow[CSR_ORIGIN_Z] = ORIGIN_RESET;
      csr_shadow[CSR_INV_CELL_X] = INV_CELL_RESET;
      csr_shadow[CSR_INV_CELL_Z] = INV_CELL_RESET;
      csr_shadow[CSR_FLOOR_Y] = FLOOR_RESET;
      csr_shadow[CSR_CEILING_Y] = CEILING_RESET;
      csr_shadow[CSR_GRID_COLUMNS] = {24'd0, SIZE_RESET};
      csr_shadow[CSR_GRID_ROWS] = {24'd0, SIZE_RESET};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: extreme samples at both grid corners, under reset registers
      push_load(0, 0, 32'h7FFF_FFFF);
      push_load(1, 0, 32'h8000_0000);
      push_load(0, 1, 32'h0000_0000);
      push_load(1, 1, 32'hFFFF_FFFF);
      push_load(127, 127, 32'h8000_0000);
      push_load(126, 127, 32'h7FFF_FFFF);
      push_load(127, 126, 32'h0001_0000);
      push_load(126, 126, 32'hFFFF_0000);
      push_query(32'h0000_0000, 32'h0000_0000);
      push_query(32'h0000_8000, 32'h0000_8000);
      push_query(32'h0000_FFFF, 32'h0000_0001);
      push_query(32'hFFFF_FFFF, 32'h8000_0000);   // below origin on both axes
      push_query(32'h7FFF_FFFF, 32'h7FFF_FFFF);   // far edge, fraction forced to 0
      push_query(32'h007F_8000, 32'h007E_8000);
      push_query(32'h007F_FFFF, 32'h0001_0000);
      wait_idle();

      for (int ph = 1; ph <= 8; ph++) begin
         setup_phase(ph);
         gap_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 49 : 13);
         repeat (PHASE_DRAWS) begin
            k = $urandom_range(99);
            if (k < 22)
               push_load($urandom_range(127), $urandom_range(127), pick_sample());
            else if (k < 32)
               push_query($urandom, $urandom);
            else
               push_query(aim(csr_shadow[CSR_ORIGIN_X], csr_shadow[CSR_INV_CELL_X],
                              csr_shadow[CSR_GRID_COLUMNS][SIZE_REG_W-1:0]),
                          aim(csr_shadow[CSR_ORIGIN_Z], csr_shadow[CSR_INV_CELL_Z],
                              csr_shadow[CSR_GRID_ROWS][SIZE_REG_W-1:0]));
         end
         wait_idle();
      end

      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/hmbs_pkg.sv
rtl/hmbs_ram.sv
rtl/hmbs_axis.sv
rtl/hmbs_lerp.sv
rtl/heightmap_bilinear_sampler_unit.sv
tb/heightmap_bilinear_sampler_unit_tb.sv
